// ----- hw/rtl/request_tracking_ledger_unit_assert.svh -----
// assertion helpers used by the ledger controller rtl
`ifndef REQUEST_TRACKING_LEDGER_UNIT_ASSERT_SVH
`define REQUEST_TRACKING_LEDGER_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define RTLU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ledger check failed");

// invariant checked on every clock edge outside reset
`define RTLU_ASSERT_ALW(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("ledger invariant failed");

`endif

// ----- hw/rtl/rtlu_pkg.sv -----
package rtlu_pkg;

  localparam int SLOTS   = 16;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int ID_W    = 32;
  localparam int EP_W    = 16;
  localparam int ENTRY_W = ID_W + 1;

  localparam logic [2:0] CMD_INIT     = 3'd0;
  localparam logic [2:0] CMD_RESET    = 3'd1;
  localparam logic [2:0] CMD_RESERVE  = 3'd2;
  localparam logic [2:0] CMD_COMMIT   = 3'd3;
  localparam logic [2:0] CMD_CANCEL   = 3'd4;
  localparam logic [2:0] CMD_COMPLETE = 3'd5;
  localparam logic [2:0] CMD_DRAIN    = 3'd6;

  localparam logic [1:0] M_UNINIT  = 2'd0;
  localparam logic [1:0] M_OPEN    = 2'd1;
  localparam logic [1:0] M_RETIRED = 2'd2;
  localparam logic [1:0] M_DRAIN   = 2'd3;

  localparam logic [3:0] ST_OK           = 4'd0;
  localparam logic [3:0] ST_INVALID      = 4'd1;
  localparam logic [3:0] ST_UNINIT       = 4'd2;
  localparam logic [3:0] ST_ALREADY      = 4'd3;
  localparam logic [3:0] ST_NOTDRAINED   = 4'd4;
  localparam logic [3:0] ST_EPOCHEX      = 4'd5;
  localparam logic [3:0] ST_DRAINING     = 4'd6;
  localparam logic [3:0] ST_SEQEX        = 4'd7;
  localparam logic [3:0] ST_FULL         = 4'd8;
  localparam logic [3:0] ST_STALE        = 4'd9;
  localparam logic [3:0] ST_OOO          = 4'd10;
  localparam logic [3:0] ST_REPLAY       = 4'd11;
  localparam logic [3:0] ST_NOTFOUND     = 4'd12;
  localparam logic [3:0] ST_NOTCOMMITTED = 4'd13;

  typedef struct packed {
    logic [3:0]      status;
    logic            key_valid;
    logic            direction;
    logic [EP_W-1:0] epoch;
    logic [ID_W-1:0] req_seq;
    logic            last;
  } res_t;

  typedef struct packed {
    logic [2:0]      command;
    logic            direction;
    logic [EP_W-1:0] epoch;
    logic [ID_W-1:0] req_seq;
  } cmd_t;

endpackage

// ----- hw/rtl/rtlu_ram.sv -----
module rtlu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/rtlu_ctrl.sv -----
`include "request_tracking_ledger_unit_assert.svh"

module rtlu_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  rtlu_pkg::cmd_t in_cmd,
  input  logic           out_free,
  output logic           idle,
  output logic           push,
  output rtlu_pkg::res_t res
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RSV  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_EV   = 2'd3;

  localparam logic [rtlu_pkg::IDX_W-1:0] LAST_IDX = rtlu_pkg::IDX_W'(rtlu_pkg::SLOTS - 1);
  localparam logic [rtlu_pkg::ID_W-1:0]  ID_MAX   = '1;
  localparam logic [rtlu_pkg::EP_W-1:0]  EP_MAX   = '1;

  logic [1:0]                   state_r, state_nxt;
  logic [1:0]                   mode_r, mode_nxt;
  logic                         own_dir_r, own_dir_nxt;
  logic [rtlu_pkg::EP_W-1:0]    own_ep_r, own_ep_nxt;
  logic [rtlu_pkg::ID_W-1:0]    next_id_r, next_id_nxt;
  logic [rtlu_pkg::CNT_W-1:0]   live_r, live_nxt;
  logic [rtlu_pkg::IDX_W-1:0]   hint_r, hint_nxt;
  logic [rtlu_pkg::SLOTS-1:0]   vld_r, vld_nxt;
  logic [rtlu_pkg::IDX_W-1:0]   ptr_r, ptr_nxt;
  logic [rtlu_pkg::IDX_W-1:0]   cnt_r, cnt_nxt;
  logic [rtlu_pkg::CNT_W-1:0]   emit_r, emit_nxt;
  rtlu_pkg::cmd_t               cmd_r, cmd_nxt;

  logic                         we;
  logic [rtlu_pkg::IDX_W-1:0]   waddr;
  logic [rtlu_pkg::ENTRY_W-1:0] wdata;
  logic [rtlu_pkg::ENTRY_W-1:0] rdata;
  logic [rtlu_pkg::IDX_W-1:0]   ptr_inc;
  logic [3:0]                   key_st, miss_st;
  logic                         rd_com;
  logic [rtlu_pkg::ID_W-1:0]    rd_id;

  rtlu_ram #(.WIDTH(rtlu_pkg::ENTRY_W), .DEPTH(rtlu_pkg::SLOTS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ptr_r),
    .rdata (rdata)
  );

  assign idle    = (state_r == S_IDLE);
  assign ptr_inc = (ptr_r == LAST_IDX) ? '0 : ptr_r + 1'b1;
  assign rd_com  = rdata[rtlu_pkg::ENTRY_W-1];
  assign rd_id   = rdata[rtlu_pkg::ID_W-1:0];

  // shared key checks on the incoming transaction
  always_comb begin
    priority if (mode_r == rtlu_pkg::M_UNINIT) key_st = rtlu_pkg::ST_UNINIT;
    else if (in_cmd.epoch == '0 || in_cmd.req_seq == '0) key_st = rtlu_pkg::ST_INVALID;
    else if (in_cmd.direction != own_dir_r || in_cmd.epoch != own_ep_r)
      key_st = rtlu_pkg::ST_STALE;
    else if (mode_r == rtlu_pkg::M_DRAIN) key_st = rtlu_pkg::ST_DRAINING;
    else key_st = rtlu_pkg::ST_OK;
  end

  always_comb begin
    priority if (mode_r == rtlu_pkg::M_RETIRED) miss_st = rtlu_pkg::ST_REPLAY;
    else if (cmd_r.req_seq < next_id_r) miss_st = rtlu_pkg::ST_REPLAY;
    else if (cmd_r.req_seq > next_id_r) miss_st = rtlu_pkg::ST_OOO;
    else miss_st = rtlu_pkg::ST_NOTFOUND;
  end

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    own_dir_nxt = own_dir_r;
    own_ep_nxt  = own_ep_r;
    next_id_nxt = next_id_r;
    live_nxt    = live_r;
    hint_nxt    = hint_r;
    vld_nxt     = vld_r;
    ptr_nxt     = ptr_r;
    cnt_nxt     = cnt_r;
    emit_nxt    = emit_r;
    cmd_nxt     = cmd_r;
    we          = 1'b0;
    waddr       = ptr_r;
    wdata       = {1'b0, cmd_r.req_seq};
    push        = 1'b0;
    res         = '0;
    res.last    = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt = in_cmd;
          push    = 1'b1;
          unique case (in_cmd.command)
            rtlu_pkg::CMD_INIT: begin
              priority if (mode_r != rtlu_pkg::M_UNINIT) res.status = rtlu_pkg::ST_ALREADY;
              else if (in_cmd.epoch == '0 || in_cmd.req_seq == '0)
                res.status = rtlu_pkg::ST_INVALID;
              else begin
                own_dir_nxt = in_cmd.direction;
                own_ep_nxt  = in_cmd.epoch;
                next_id_nxt = in_cmd.req_seq;
                mode_nxt    = rtlu_pkg::M_OPEN;
                res.status  = rtlu_pkg::ST_OK;
              end
            end
            rtlu_pkg::CMD_RESET: begin
              priority if (mode_r == rtlu_pkg::M_UNINIT) res.status = rtlu_pkg::ST_UNINIT;
              else if (mode_r != rtlu_pkg::M_DRAIN) res.status = rtlu_pkg::ST_NOTDRAINED;
              else if (in_cmd.epoch == '0 || in_cmd.req_seq == '0 ||
                       in_cmd.direction != own_dir_r) res.status = rtlu_pkg::ST_INVALID;
              else if (own_ep_r == EP_MAX) res.status = rtlu_pkg::ST_EPOCHEX;
              else if (in_cmd.epoch <= own_ep_r) res.status = rtlu_pkg::ST_STALE;
              else begin
                own_ep_nxt  = in_cmd.epoch;
                next_id_nxt = in_cmd.req_seq;
                live_nxt    = '0;
                hint_nxt    = '0;
                mode_nxt    = rtlu_pkg::M_OPEN;
                res.status  = rtlu_pkg::ST_OK;
              end
            end
            rtlu_pkg::CMD_RESERVE: begin
              priority if (key_st != rtlu_pkg::ST_OK) res.status = key_st;
              else if (mode_r == rtlu_pkg::M_RETIRED) res.status = rtlu_pkg::ST_SEQEX;
              else if (in_cmd.req_seq < next_id_r) res.status = rtlu_pkg::ST_REPLAY;
              else if (in_cmd.req_seq > next_id_r) res.status = rtlu_pkg::ST_OOO;
              else begin
                push      = 1'b0;
                ptr_nxt   = hint_r;
                cnt_nxt   = '0;
                state_nxt = S_RSV;
              end
            end
            rtlu_pkg::CMD_COMMIT, rtlu_pkg::CMD_CANCEL, rtlu_pkg::CMD_COMPLETE: begin
              if (key_st != rtlu_pkg::ST_OK) begin
                res.status = key_st;
              end else begin
                push      = 1'b0;
                ptr_nxt   = '0;
                state_nxt = S_RD;
              end
            end
            rtlu_pkg::CMD_DRAIN: begin
              priority if (mode_r == rtlu_pkg::M_UNINIT) res.status = rtlu_pkg::ST_UNINIT;
              else if (mode_r == rtlu_pkg::M_DRAIN) res.status = rtlu_pkg::ST_OK;
              else if (live_r == '0) begin
                res.status  = rtlu_pkg::ST_OK;
                vld_nxt     = '0;
                next_id_nxt = '0;
                hint_nxt    = '0;
                mode_nxt    = rtlu_pkg::M_DRAIN;
              end else begin
                push      = 1'b0;
                ptr_nxt   = '0;
                emit_nxt  = '0;
                state_nxt = S_RD;
              end
            end
            default: res.status = rtlu_pkg::ST_INVALID;
          endcase
        end
      end

      // round-robin walk over the valid bits from the hint
      S_RSV: begin
        if (out_free) begin
          if (!vld_r[ptr_r]) begin
            we               = 1'b1;
            vld_nxt[ptr_r]   = 1'b1;
            live_nxt         = live_r + 1'b1;
            hint_nxt         = ptr_inc;
            if (cmd_r.req_seq == ID_MAX) begin
              next_id_nxt = '0;
              mode_nxt    = rtlu_pkg::M_RETIRED;
            end else begin
              next_id_nxt = cmd_r.req_seq + 1'b1;
            end
            push       = 1'b1;
            res.status = rtlu_pkg::ST_OK;
            state_nxt  = S_IDLE;
          end else if (cnt_r == LAST_IDX) begin
            push       = 1'b1;
            res.status = rtlu_pkg::ST_FULL;
            state_nxt  = S_IDLE;
          end else begin
            ptr_nxt = ptr_inc;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end

      S_RD: state_nxt = S_EV;

      S_EV: begin
        if (out_free) begin
          if (cmd_r.command == rtlu_pkg::CMD_DRAIN) begin
            if (vld_r[ptr_r]) begin
              push           = 1'b1;
              res.status     = rtlu_pkg::ST_OK;
              res.key_valid  = 1'b1;
              res.direction  = own_dir_r;
              res.epoch      = own_ep_r;
              res.req_seq    = rd_id;
              res.last       = (rtlu_pkg::CNT_W'(emit_r + 1'b1) == live_r);
              emit_nxt       = emit_r + 1'b1;
            end
            if (ptr_r == LAST_IDX) begin
              vld_nxt     = '0;
              next_id_nxt = '0;
              live_nxt    = '0;
              hint_nxt    = '0;
              mode_nxt    = rtlu_pkg::M_DRAIN;
              state_nxt   = S_IDLE;
            end else begin
              ptr_nxt   = ptr_inc;
              state_nxt = S_RD;
            end
          end else if (vld_r[ptr_r] && rd_id == cmd_r.req_seq) begin
            push      = 1'b1;
            state_nxt = S_IDLE;
            unique case (cmd_r.command)
              rtlu_pkg::CMD_COMMIT: begin
                if (rd_com) begin
                  res.status = rtlu_pkg::ST_REPLAY;
                end else begin
                  we             = 1'b1;
                  wdata          = {1'b1, cmd_r.req_seq};
                  res.status     = rtlu_pkg::ST_OK;
                  res.key_valid  = 1'b1;
                  res.direction  = cmd_r.direction;
                  res.epoch      = cmd_r.epoch;
                  res.req_seq    = cmd_r.req_seq;
                end
              end
              default: begin
                // cancel frees any live entry, complete needs it committed
                if (cmd_r.command == rtlu_pkg::CMD_COMPLETE && !rd_com) begin
                  res.status = rtlu_pkg::ST_NOTCOMMITTED;
                end else begin
                  vld_nxt[ptr_r] = 1'b0;
                  live_nxt       = live_r - 1'b1;
                  hint_nxt       = ptr_r;
                  res.status     = rtlu_pkg::ST_OK;
                end
              end
            endcase
          end else if (ptr_r == LAST_IDX) begin
            push       = 1'b1;
            res.status = miss_st;
            state_nxt  = S_IDLE;
          end else begin
            ptr_nxt   = ptr_inc;
            state_nxt = S_RD;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      mode_r    <= rtlu_pkg::M_UNINIT;
      own_dir_r <= 1'b0;
      own_ep_r  <= '0;
      next_id_r <= '0;
      live_r    <= '0;
      hint_r    <= '0;
      vld_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      mode_r    <= mode_nxt;
      own_dir_r <= own_dir_nxt;
      own_ep_r  <= own_ep_nxt;
      next_id_r <= next_id_nxt;
      live_r    <= live_nxt;
      hint_r    <= hint_nxt;
      vld_r     <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    cnt_r  <= cnt_nxt;
    emit_r <= emit_nxt;
    cmd_r  <= cmd_nxt;
  end

  `RTLU_ASSERT_ALW(a_live_matches_valid, $countones(vld_r) == 32'(live_r))
  `RTLU_ASSERT_IMP(a_push_has_room, push, out_free)
  `RTLU_ASSERT_IMP(a_eval_follows_read, state_r == S_EV && $past(state_r) != S_EV,
    $past(state_r) == S_RD)

endmodule

// ----- hw/rtl/request_tracking_ledger_unit.sv -----
// simple and rejected commands answer from idle; reserve walks the valid bits
// commit/cancel/complete/drain walk the slot memory entry by entry, read then evaluate
// one transaction at a time; drain emits one key per live slot
// the slot walk through the single-port-read memory sets how long a command takes
// reset (rst_n, synchronous, low) leaves the ledger uninitialized with every slot free
module request_tracking_ledger_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_command,
  input  logic                      in_key_direction,
  input  logic [rtlu_pkg::EP_W-1:0] in_key_epoch,
  input  logic [rtlu_pkg::ID_W-1:0] in_req_seq,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [3:0]                out_status,
  output logic                      out_key_valid,
  output logic                      out_out_direction,
  output logic [rtlu_pkg::EP_W-1:0] out_out_epoch,
  output logic [rtlu_pkg::ID_W-1:0] out_out_req_seq,
  output logic                      out_last
);

  logic           idle, push, out_free, in_fire;
  logic           out_valid_r, out_valid_nxt;
  rtlu_pkg::res_t res, res_r;
  rtlu_pkg::cmd_t in_cmd;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !idle || !out_free;
  assign in_fire  = in_valid && !in_stall;

  assign in_cmd.command   = in_command;
  assign in_cmd.direction = in_key_direction;
  assign in_cmd.epoch     = in_key_epoch;
  assign in_cmd.req_seq   = in_req_seq;

  rtlu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_cmd   (in_cmd),
    .out_free (out_free),
    .idle     (idle),
    .push     (push),
    .res      (res)
  );

  assign out_valid_nxt = push || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = res_r.status;
  assign out_key_valid     = res_r.key_valid;
  assign out_out_direction = res_r.direction;
  assign out_out_epoch     = res_r.epoch;
  assign out_out_req_seq   = res_r.req_seq;
  assign out_last          = res_r.last;

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;

  localparam logic [1:0] SL_FREE = 2'd0;
  localparam logic [1:0] SL_RES  = 2'd1;
  localparam logic [1:0] SL_COM  = 2'd2;
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_RANDOM = 260;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_command = rtlu_pkg::CMD_INIT;
  logic in_key_direction = 1'b0;
  logic [rtlu_pkg::EP_W-1:0] in_key_epoch = '0;
  logic [rtlu_pkg::ID_W-1:0] in_req_seq = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] out_status;
  logic out_key_valid;
  logic out_out_direction;
  logic [rtlu_pkg::EP_W-1:0] out_out_epoch;
  logic [rtlu_pkg::ID_W-1:0] out_out_req_seq;
  logic out_last;

  request_tracking_ledger_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_key_direction(in_key_direction),
    .in_key_epoch(in_key_epoch), .in_req_seq(in_req_seq),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_key_valid(out_key_valid),
    .out_out_direction(out_out_direction), .out_out_epoch(out_out_epoch),
    .out_out_req_seq(out_out_req_seq), .out_last(out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow ledger state
  logic [1:0] lg_mode;
  logic lg_dir;
  logic [rtlu_pkg::EP_W-1:0] lg_epoch;
  logic [rtlu_pkg::ID_W-1:0] lg_next_id;
  int lg_live;
  int lg_hint;
  logic [rtlu_pkg::ID_W-1:0] lg_slot_id[rtlu_pkg::SLOTS];
  logic [1:0] lg_slot_mode[rtlu_pkg::SLOTS];

  rtlu_pkg::res_t expected_q[$];
  int fails = 0;
  int cycles = 0;
  bit idle_en = 1'b1;
  bit hold_rx = 1'b0;

  function automatic void push_res(logic [3:0] st, logic kv, logic d,
                                   logic [rtlu_pkg::EP_W-1:0] e,
                                   logic [rtlu_pkg::ID_W-1:0] id, logic lst);
    rtlu_pkg::res_t r;
    r.status = st; r.key_valid = kv; r.direction = d;
    r.epoch = e; r.req_seq = id; r.last = lst;
    expected_q.push_back(r);
  endfunction

  function automatic int find_live(logic [rtlu_pkg::ID_W-1:0] id);
    for (int i = 0; i < rtlu_pkg::SLOTS; i++)
      if (lg_slot_mode[i] != SL_FREE && lg_slot_id[i] == id) return i;
    return -1;
  endfunction

  function automatic logic [3:0] classify_missing(logic [rtlu_pkg::ID_W-1:0] id);
    if (lg_mode == rtlu_pkg::M_DRAIN) return rtlu_pkg::ST_DRAINING;
    if (lg_mode == rtlu_pkg::M_RETIRED) return rtlu_pkg::ST_REPLAY;
    if (id < lg_next_id) return rtlu_pkg::ST_REPLAY;
    if (id > lg_next_id) return rtlu_pkg::ST_OOO;
    return rtlu_pkg::ST_NOTFOUND;
  endfunction

  function automatic logic [3:0] key_check(rtlu_pkg::cmd_t c);
    if (lg_mode == rtlu_pkg::M_UNINIT) return rtlu_pkg::ST_UNINIT;
    if (c.epoch == 0 || c.req_seq == 0) return rtlu_pkg::ST_INVALID;
    if (c.direction != lg_dir || c.epoch != lg_epoch) return rtlu_pkg::ST_STALE;
    if (lg_mode == rtlu_pkg::M_DRAIN) return rtlu_pkg::ST_DRAINING;
    return rtlu_pkg::ST_OK;
  endfunction

  function automatic void release_slot(int i);
    lg_slot_id[i] = '0;
    lg_slot_mode[i] = SL_FREE;
    if (lg_live > 0) lg_live--;
    lg_hint = i;
  endfunction

  function automatic void ledger_reset();
    lg_mode = rtlu_pkg::M_UNINIT; lg_dir = 1'b0; lg_epoch = '0; lg_next_id = '0;
    lg_live = 0; lg_hint = 0;
    for (int i = 0; i < rtlu_pkg::SLOTS; i++) begin
      lg_slot_id[i] = '0;
      lg_slot_mode[i] = SL_FREE;
    end
  endfunction

  // computes the results of one accepted transaction and queues them
  function automatic void predict_ledger(rtlu_pkg::cmd_t c);
    logic [3:0] st;
    int idx;
    int n;
    st = rtlu_pkg::ST_OK;
    case (c.command)
      rtlu_pkg::CMD_INIT: begin
        if (lg_mode != rtlu_pkg::M_UNINIT) st = rtlu_pkg::ST_ALREADY;
        else if (c.epoch == 0 || c.req_seq == 0) st = rtlu_pkg::ST_INVALID;
        else begin
          lg_dir = c.direction; lg_epoch = c.epoch; lg_next_id = c.req_seq;
          lg_mode = rtlu_pkg::M_OPEN;
        end
      end
      rtlu_pkg::CMD_RESET: begin
        if (lg_mode == rtlu_pkg::M_UNINIT) st = rtlu_pkg::ST_UNINIT;
        else if (lg_mode != rtlu_pkg::M_DRAIN) st = rtlu_pkg::ST_NOTDRAINED;
        else if (c.epoch == 0 || c.req_seq == 0 || c.direction != lg_dir)
          st = rtlu_pkg::ST_INVALID;
        else if (lg_epoch == '1) st = rtlu_pkg::ST_EPOCHEX;
        else if (c.epoch <= lg_epoch) st = rtlu_pkg::ST_STALE;
        else begin
          lg_epoch = c.epoch; lg_next_id = c.req_seq;
          lg_live = 0; lg_hint = 0; lg_mode = rtlu_pkg::M_OPEN;
        end
      end
      rtlu_pkg::CMD_RESERVE: begin
        st = key_check(c);
        if (st == rtlu_pkg::ST_OK) begin
          if (lg_mode == rtlu_pkg::M_RETIRED) st = rtlu_pkg::ST_SEQEX;
          else if (c.req_seq < lg_next_id) st = rtlu_pkg::ST_REPLAY;
          else if (c.req_seq > lg_next_id) st = rtlu_pkg::ST_OOO;
          else begin
            idx = -1;
            for (int k = 0; k < rtlu_pkg::SLOTS; k++)
              if (idx < 0 && lg_slot_mode[(lg_hint + k) % rtlu_pkg::SLOTS] == SL_FREE)
                idx = (lg_hint + k) % rtlu_pkg::SLOTS;
            if (idx < 0) st = rtlu_pkg::ST_FULL;
            else begin
              lg_slot_id[idx] = c.req_seq;
              lg_slot_mode[idx] = SL_RES;
              lg_live++;
              lg_hint = (idx + 1) % rtlu_pkg::SLOTS;
              if (c.req_seq == '1) begin
                lg_next_id = '0;
                lg_mode = rtlu_pkg::M_RETIRED;
              end else lg_next_id = c.req_seq + 1;
            end
          end
        end
      end
      rtlu_pkg::CMD_COMMIT, rtlu_pkg::CMD_CANCEL, rtlu_pkg::CMD_COMPLETE: begin
        st = key_check(c);
        if (st == rtlu_pkg::ST_OK) begin
          idx = find_live(c.req_seq);
          if (idx < 0) st = classify_missing(c.req_seq);
          else if (c.command == rtlu_pkg::CMD_COMMIT) begin
            if (lg_slot_mode[idx] != SL_RES) st = rtlu_pkg::ST_REPLAY;
            else begin
              lg_slot_mode[idx] = SL_COM;
              push_res(rtlu_pkg::ST_OK, 1'b1, c.direction, c.epoch, c.req_seq, 1'b1);
              return;
            end
          end else if (c.command == rtlu_pkg::CMD_COMPLETE && lg_slot_mode[idx] != SL_COM)
            st = rtlu_pkg::ST_NOTCOMMITTED;
          else release_slot(idx);
        end
      end
      rtlu_pkg::CMD_DRAIN: begin
        if (lg_mode == rtlu_pkg::M_UNINIT) st = rtlu_pkg::ST_UNINIT;
        else if (lg_mode != rtlu_pkg::M_DRAIN) begin
          n = 0;
          for (int i = 0; i < rtlu_pkg::SLOTS; i++) begin
            if (lg_slot_mode[i] != SL_FREE) begin
              push_res(rtlu_pkg::ST_OK, 1'b1, lg_dir, lg_epoch, lg_slot_id[i], 1'b0);
              n++;
            end
            lg_slot_id[i] = '0;
            lg_slot_mode[i] = SL_FREE;
          end
          lg_next_id = '0; lg_live = 0; lg_hint = 0; lg_mode = rtlu_pkg::M_DRAIN;
          if (n > 0) begin
            expected_q[$].last = 1'b1;
            return;
          end
        end
      end
      default: st = rtlu_pkg::ST_INVALID;
    endcase
    push_res(st, 1'b0, 1'b0, '0, '0, 1'b1);
  endfunction

  // offers one transaction and holds it until accepted
  task automatic send_cmd(rtlu_pkg::cmd_t c, bit typed, logic [3:0] typed_st);
    while (idle_en && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= c.command;
    in_key_direction <= c.direction;
    in_key_epoch <= c.epoch;
    in_req_seq <= c.req_seq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_ledger(c);
    if (typed) begin
      void'(expected_q.pop_back());
      push_res(typed_st, 1'b0, 1'b0, '0, '0, 1'b1);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic rtlu_pkg::cmd_t mk(logic [2:0] op, logic d, logic [rtlu_pkg::EP_W-1:0] e,
                                        logic [rtlu_pkg::ID_W-1:0] id);
    rtlu_pkg::cmd_t c;
    c.command = op; c.direction = d; c.epoch = e; c.req_seq = id;
    return c;
  endfunction

  function automatic logic [rtlu_pkg::ID_W-1:0] pick_live(logic [1:0] want);
    int cand[$];
    for (int i = 0; i < rtlu_pkg::SLOTS; i++)
      if (lg_slot_mode[i] == want) cand.push_back(i);
    if (cand.size() == 0) return lg_next_id;
    return lg_slot_id[cand[$urandom_range(cand.size() - 1)]];
  endfunction

  // mostly well-formed traffic against the current ledger, some noise
  function automatic rtlu_pkg::cmd_t random_cmd();
    int r;
    logic [rtlu_pkg::ID_W-1:0] id0;
    logic [rtlu_pkg::EP_W-1:0] e;
    r = $urandom_range(99);
    id0 = ($urandom_range(9) == 0) ? 32'hFFFF_FFF4 - $urandom_range(8) : $urandom;
    if (id0 == 0) id0 = 1;
    if (r < 12) return mk(3'($urandom_range(7)), 1'($urandom_range(1)), 16'($urandom),
                          $urandom);
    if (lg_mode == rtlu_pkg::M_UNINIT) begin
      e = 16'($urandom);
      if (e == 0) e = 1;
      return mk(rtlu_pkg::CMD_INIT, 1'($urandom_range(1)), e, id0);
    end
    if (lg_mode == rtlu_pkg::M_DRAIN) begin
      e = (lg_epoch > 16'hFFFF - 16'd400) ? 16'hFFFF
                                           : 16'(lg_epoch + $urandom_range(1, 400));
      return mk(rtlu_pkg::CMD_RESET, lg_dir, e, id0);
    end
    if (r < 15) return mk(rtlu_pkg::CMD_RESERVE, lg_dir, lg_epoch,
                          lg_next_id + $urandom_range(1, 3));
    if (r < 18) return mk(3'($urandom_range(rtlu_pkg::CMD_COMMIT, rtlu_pkg::CMD_COMPLETE)),
                          lg_dir, lg_epoch, lg_next_id - $urandom_range(0, 2));
    if (r < 50) return mk(rtlu_pkg::CMD_RESERVE, lg_dir, lg_epoch, lg_next_id);
    if (r < 68) return mk(rtlu_pkg::CMD_COMMIT, lg_dir, lg_epoch, pick_live(SL_RES));
    if (r < 84) return mk(rtlu_pkg::CMD_COMPLETE, lg_dir, lg_epoch, pick_live(SL_COM));
    if (r < 94) return mk(rtlu_pkg::CMD_CANCEL, lg_dir, lg_epoch,
                          pick_live(2'($urandom_range(1, 2))));
    return mk(rtlu_pkg::CMD_DRAIN, 1'($urandom_range(1)), 16'($urandom), $urandom);
  endfunction

  typedef struct {
    rtlu_pkg::cmd_t c;
    bit typed;
    logic [3:0] st;
  } row_t;

  row_t directed[] = '{
    '{mk(rtlu_pkg::CMD_DRAIN, 0, 0, 0), 1, rtlu_pkg::ST_UNINIT},
    '{mk(rtlu_pkg::CMD_RESERVE, 1, 16'hFFFE, 32'hFFFF_FFFE), 1, rtlu_pkg::ST_UNINIT},
    '{mk(rtlu_pkg::CMD_RESET, 1, 16'h0010, 32'h1), 1, rtlu_pkg::ST_UNINIT},
    '{mk(rtlu_pkg::CMD_INIT, 1, 16'h0, 32'h5), 1, rtlu_pkg::ST_INVALID},
    '{mk(rtlu_pkg::CMD_INIT, 1, 16'h5, 32'h0), 1, rtlu_pkg::ST_INVALID},
    '{mk(CMD_UNUSED, 1, 16'hFFFF, 32'hFFFF_FFFF), 1, rtlu_pkg::ST_INVALID},
    '{mk(rtlu_pkg::CMD_INIT, 1, 16'h0100, 32'hFFFF_FFFE), 1, rtlu_pkg::ST_OK},
    '{mk(rtlu_pkg::CMD_INIT, 0, 16'h0200, 32'h1), 1, rtlu_pkg::ST_ALREADY},
    '{mk(rtlu_pkg::CMD_RESERVE, 1, 16'h0100, 32'hFFFF_FFFE), 0, rtlu_pkg::ST_OK},
    '{mk(rtlu_pkg::CMD_RESERVE, 1, 16'h0100, 32'hFFFF_FFFF), 0, rtlu_pkg::ST_OK},
    '{mk(rtlu_pkg::CMD_RESERVE, 1, 16'h0100, 32'h1), 1, rtlu_pkg::ST_SEQEX},
    '{mk(rtlu_pkg::CMD_COMMIT, 1, 16'h0100, 32'hFFFF_FFFE), 0, rtlu_pkg::ST_OK},
    '{mk(rtlu_pkg::CMD_COMMIT, 1, 16'h0100, 32'hFFFF_FFFE), 1, rtlu_pkg::ST_REPLAY},
    '{mk(rtlu_pkg::CMD_COMPLETE, 1, 16'h0100, 32'hFFFF_FFFF), 1,
      rtlu_pkg::ST_NOTCOMMITTED},
    '{mk(rtlu_pkg::CMD_COMPLETE, 1, 16'h0100, 32'hFFFF_FFFE), 0, rtlu_pkg::ST_OK},
    '{mk(rtlu_pkg::CMD_CANCEL, 1, 16'h0100, 32'h5), 1, rtlu_pkg::ST_REPLAY},
    '{mk(rtlu_pkg::CMD_COMMIT, 0, 16'h0100, 32'hFFFF_FFFF), 1, rtlu_pkg::ST_STALE},
    '{mk(rtlu_pkg::CMD_RESET, 1, 16'h0200, 32'h1), 1, rtlu_pkg::ST_NOTDRAINED},
    '{mk(rtlu_pkg::CMD_DRAIN, 0, 0, 0), 0, rtlu_pkg::ST_OK},
    '{mk(rtlu_pkg::CMD_DRAIN, 1, 16'hFFFF, 32'hFFFF_FFFF), 1, rtlu_pkg::ST_OK},
    '{mk(rtlu_pkg::CMD_COMMIT, 1, 16'h0100, 32'h7), 1, rtlu_pkg::ST_DRAINING},
    '{mk(rtlu_pkg::CMD_RESET, 1, 16'h00FF, 32'h1), 1, rtlu_pkg::ST_STALE},
    '{mk(rtlu_pkg::CMD_RESET, 0, 16'h0200, 32'h1), 1, rtlu_pkg::ST_INVALID},
    '{mk(rtlu_pkg::CMD_RESET, 1, 16'h0300, 32'h10), 1, rtlu_pkg::ST_OK},
    '{mk(rtlu_pkg::CMD_RESERVE, 1, 16'h0300, 32'h12), 1, rtlu_pkg::ST_OOO},
    '{mk(rtlu_pkg::CMD_CANCEL, 1, 16'h0300, 32'h10), 1, rtlu_pkg::ST_NOTFOUND}
  };

  // result side: checks every result of each accepted transaction and stalls at random or during the hold-off
  always @(posedge clk) begin
    rtlu_pkg::res_t want;
    bit bad;
    bad = 1'b0;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected transaction: status %0d id %0h", out_status, out_out_req_seq);
        bad = 1'b1;
      end else begin
        want = expected_q.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, out_status);
          bad = 1'b1;
        end
        if (out_key_valid !== want.key_valid) begin
          $error("key_valid: expected %0d actual %0d", want.key_valid, out_key_valid);
          bad = 1'b1;
        end
        if (out_out_direction !== want.direction) begin
          $error("out_direction: expected %0d actual %0d", want.direction, out_out_direction);
          bad = 1'b1;
        end
        if (out_out_epoch !== want.epoch) begin
          $error("out_epoch: expected %0h actual %0h", want.epoch, out_out_epoch);
          bad = 1'b1;
        end
        if (out_out_req_seq !== want.req_seq) begin
          $error("out_req_seq: expected %0h actual %0h", want.req_seq, out_out_req_seq);
          bad = 1'b1;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d actual %0d", want.last, out_last);
          bad = 1'b1;
        end
      end
    end
    if (bad) fails <= fails + 1;
    out_stall <= hold_rx || (idle_en && $urandom_range(99) < 15);
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    repeat (600) @(posedge clk);
    hold_rx = 1'b1;
    repeat (400) @(posedge clk);
    hold_rx = 1'b0;
  end

  initial begin
    ledger_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_cmd(directed[i].c, directed[i].typed, directed[i].st);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 100) idle_en = 1'b0;
      if (i == 160) idle_en = 1'b1;
      if (i == 220) wait_drained();
      send_cmd(random_cmd(), 0, rtlu_pkg::ST_OK);
    end
    // unless the epoch is at its top, fill every slot, overflow and drain a full table; then exhaust it
    wait_drained();
    if (lg_mode != rtlu_pkg::M_DRAIN)
      send_cmd(mk(rtlu_pkg::CMD_DRAIN, 0, 0, 0), 0, rtlu_pkg::ST_OK);
    if (lg_epoch != 16'hFFFF) begin
      send_cmd(mk(rtlu_pkg::CMD_RESET, lg_dir, 16'hFFFF, 32'h1), 0, rtlu_pkg::ST_OK);
      for (int i = 0; i <= rtlu_pkg::SLOTS; i++)
        send_cmd(mk(rtlu_pkg::CMD_RESERVE, lg_dir, lg_epoch, lg_next_id), 0, rtlu_pkg::ST_OK);
      send_cmd(mk(rtlu_pkg::CMD_DRAIN, 0, 0, 0), 0, rtlu_pkg::ST_OK);
    end
    send_cmd(mk(rtlu_pkg::CMD_RESET, lg_dir, 16'hFFFF, 32'h1), 1, rtlu_pkg::ST_EPOCHEX);
    wait_drained();
    repeat (40) @(posedge clk);
    if (fails == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/rtlu_pkg.sv
hw/rtl/rtlu_ram.sv
hw/rtl/rtlu_ctrl.sv
hw/rtl/request_tracking_ledger_unit.sv
tb/sv/tb_top.sv
